// File: src/puaq_pkg.sv
// shared constants and types for the primary user activity query block
`default_nettype none
package puaq_pkg;
   localparam int MaxUsers   = 16;
   localparam int MaxWindows = 64;

   localparam logic [1:0] CMD_WR_DESC  = 2'd0;
   localparam logic [1:0] CMD_WR_WIN   = 2'd1;
   localparam logic [1:0] CMD_Q_LOC    = 2'd2;
   localparam logic [1:0] CMD_Q_ANY    = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic [3:0]         user_index;
      logic [5:0]         window_index;
      logic [7:0]         channel;
      logic signed [23:0] x_pos;
      logic signed [23:0] y_pos;
      logic [23:0]        radius;
      logic [6:0]         window_count;
      logic [47:0]        time_start;
      logic [47:0]        time_second;
   } req_type;

   typedef struct packed {
      logic        active;
      logic [47:0] off_time;
      logic [3:0]  matched_user;
      logic [5:0]  matched_window;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DESC, ST_DX, ST_DY, ST_RR, ST_CMP, ST_WADDR, ST_WREAD, ST_WTEST,
      ST_NEXT, ST_DONE
   } state_type;
endpackage
`default_nettype wire

// File: src/puaq_if.sv
// valid/ready channel interfaces for request and response
`default_nettype none
interface puaq_req_if;
   logic              valid;
   logic              ready;
   puaq_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface puaq_rsp_if;
   logic              valid;
   logic              ready;
   puaq_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/puaq_sqr.sv
// registered shared 25x25 squaring unit
`default_nettype none
module puaq_sqr (
   input  wire logic        clock,
   input  wire logic [24:0] op_in,
   output logic [49:0]      sq_out
);
   logic [49:0] sq_ff;
   always_ff @(posedge clock) begin
      sq_ff <= op_in * op_in;
   end
   assign sq_out = sq_ff;
endmodule
`default_nettype wire

// File: src/primary_user_activity_query_core.sv
// top level: entry table, window memory and query sequencer
// Usage: requests transfer on req (command plus operands), each request gives
// exactly one response on rsp. Writes respond via ST_DESC and ST_DONE. A query
// walks entries in order: a located query runs the distance test of each
// entry through the one shared squaring unit (ST_NEXT, ST_DX, ST_DY, ST_RR,
// ST_CMP), then ST_WADDR, ST_WREAD and ST_WTEST for each window read from the
// window memory (registered read port) and ST_NEXT to leave the entry.
// csr_we/csr_wdata set the entry count. Reset clears the entry count and
// sequencer; the tables are undefined until written. req is not ready while a
// request is in progress; when rsp stalls the response holds in its register
// and the next request waits.
`default_nettype none
module primary_user_activity_query_core #(
   parameter int MAX_USERS   = puaq_pkg::MaxUsers,
   parameter int MAX_WINDOWS = puaq_pkg::MaxWindows
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_we,
   input  wire logic [4:0] csr_wdata,
   puaq_req_if.sink   req,
   puaq_rsp_if.source rsp
);
   localparam int UW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int WW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int CW = $clog2(MAX_USERS + 1);

   puaq_pkg::state_type st_ff, st_in;
   puaq_pkg::req_type q_ff, q_in;
   puaq_pkg::rsp_type r_ff, r_in;
   logic rv_ff, rv_in;
   logic [4:0] cnt_ff;
   logic [UW:0] u_ff, u_in;
   logic [WW:0] w_ff, w_in;
   logic [WW:0] nw_ff, nw_in;
   logic [50:0] acc_ff, acc_in;
   logic        chok_ff, chok_in;

   logic [7:0]  m_ch [MAX_USERS];
   logic [23:0] m_x [MAX_USERS];
   logic [23:0] m_y [MAX_USERS];
   logic [23:0] m_r [MAX_USERS];
   logic [6:0]  m_wc [MAX_USERS];
   logic [95:0] win [MAX_USERS * MAX_WINDOWS];
   logic [95:0] wrd_ff;
   logic [UW+WW-1:0] raddr;

   logic [24:0] sq_op;
   logic [49:0] sq;
   logic [CW-1:0] users;
   logic [48:0] qend;
   logic [UW-1:0] ui;
   logic [6:0] wcs;

   puaq_sqr u_sqr (.clock(clock), .op_in(sq_op), .sq_out(sq));

   assign ui = u_ff[UW-1:0];
   assign users = (cnt_ff > 5'(MAX_USERS)) ? CW'(MAX_USERS) : CW'(cnt_ff);
   assign qend = {1'b0, q_ff.time_start} + {1'b0, q_ff.time_second};
   assign raddr = {ui, w_ff[WW-1:0]};
   assign wcs = m_wc[ui];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= puaq_pkg::ST_IDLE;
         rv_ff <= 1'b0;
         cnt_ff <= 5'd0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
         if (csr_we) cnt_ff <= csr_wdata;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      u_ff <= u_in;
      w_ff <= w_in;
      nw_ff <= nw_in;
      acc_ff <= acc_in;
      chok_ff <= chok_in;
      wrd_ff <= win[raddr];
      if (st_ff == puaq_pkg::ST_DESC) begin
         if (q_ff.command == puaq_pkg::CMD_WR_DESC && 32'(q_ff.user_index) < MAX_USERS) begin
            m_ch[q_ff.user_index[UW-1:0]] <= q_ff.channel;
            m_x[q_ff.user_index[UW-1:0]]  <= q_ff.x_pos;
            m_y[q_ff.user_index[UW-1:0]]  <= q_ff.y_pos;
            m_r[q_ff.user_index[UW-1:0]]  <= q_ff.radius;
            m_wc[q_ff.user_index[UW-1:0]] <= q_ff.window_count;
         end
         if (q_ff.command == puaq_pkg::CMD_WR_WIN && 32'(q_ff.user_index) < MAX_USERS &&
             32'(q_ff.window_index) < MAX_WINDOWS)
            win[{q_ff.user_index[UW-1:0], q_ff.window_index[WW-1:0]}] <=
               {q_ff.time_start, q_ff.time_second};
      end
   end

   assign req.ready = (st_ff == puaq_pkg::ST_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.data  = r_ff;

   always_comb begin
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      st_in = st_ff; q_in = q_ff; r_in = r_ff; rv_in = rv_ff;
      u_in = u_ff; w_in = w_ff; nw_in = nw_ff; acc_in = acc_ff; chok_in = chok_ff;
      dx = 25'(signed'(q_ff.x_pos)) - 25'(signed'(m_x[ui]));
      dy = 25'(signed'(q_ff.y_pos)) - 25'(signed'(m_y[ui]));
      sq_op = 25'd0;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (st_ff)
         puaq_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               q_in = req.data;
               r_in = '0;
               u_in = '0;
               st_in = (req.data.command == puaq_pkg::CMD_WR_DESC ||
                        req.data.command == puaq_pkg::CMD_WR_WIN) ?
                       puaq_pkg::ST_DESC : puaq_pkg::ST_NEXT;
            end
         end
         puaq_pkg::ST_DESC: st_in = puaq_pkg::ST_DONE;
         puaq_pkg::ST_NEXT: begin
            // start of one entry
            w_in = '0;
            nw_in = (wcs > 7'(MAX_WINDOWS)) ? (WW+1)'(MAX_WINDOWS) : (WW+1)'(wcs);
            if (u_ff >= (UW+1)'(users)) st_in = puaq_pkg::ST_DONE;
            else if (q_ff.command == puaq_pkg::CMD_Q_LOC) begin
               chok_in = (m_ch[ui] == q_ff.channel);
               sq_op = dx[24] ? -dx : dx;
               st_in = puaq_pkg::ST_DX;
            end else st_in = puaq_pkg::ST_WADDR;
         end
         puaq_pkg::ST_DX: begin
            // squared x difference is out of the unit now
            acc_in = 51'(sq);
            sq_op = dy[24] ? -dy : dy;
            st_in = puaq_pkg::ST_DY;
         end
         puaq_pkg::ST_DY: begin
            acc_in = acc_ff + 51'(sq);
            sq_op = {1'b0, m_r[ui]};
            st_in = puaq_pkg::ST_RR;
         end
         puaq_pkg::ST_RR: begin
            // hold the radius operand so its square is still there for the compare
            sq_op = {1'b0, m_r[ui]};
            st_in = puaq_pkg::ST_CMP;
         end
         puaq_pkg::ST_CMP: begin
            if (chok_ff && acc_ff <= 51'(sq)) st_in = puaq_pkg::ST_WADDR;
            else begin
               u_in = u_ff + 1'b1;
               st_in = puaq_pkg::ST_NEXT;
            end
         end
         puaq_pkg::ST_WADDR: begin
            if (w_ff >= nw_ff) begin
               u_in = u_ff + 1'b1;
               st_in = puaq_pkg::ST_NEXT;
            end else st_in = puaq_pkg::ST_WREAD;
         end
         puaq_pkg::ST_WREAD: st_in = puaq_pkg::ST_WTEST;
         puaq_pkg::ST_WTEST: begin
            if ({1'b0, wrd_ff[95:48]} <= qend && wrd_ff[47:0] >= q_ff.time_start) begin
               r_in.active = 1'b1;
               r_in.off_time = wrd_ff[47:0];
               r_in.matched_user = 4'(ui);
               r_in.matched_window = 6'(w_ff[WW-1:0]);
               st_in = puaq_pkg::ST_DONE;
            end else if ({1'b0, wrd_ff[95:48]} > qend) begin
               u_in = u_ff + 1'b1;
               st_in = puaq_pkg::ST_NEXT;
            end else begin
               w_in = w_ff + 1'b1;
               st_in = puaq_pkg::ST_WADDR;
            end
         end
         puaq_pkg::ST_DONE: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               st_in = puaq_pkg::ST_IDLE;
            end
         end
         default: st_in = puaq_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire
